// ===== sv/mbd_pkg.sv =====
// Shared types and constants for the mip level box downsampler.
// Used by the controller, the datapath and the top level; no dependencies.
package mbd_pkg;

   localparam int CFG_W     = 13;
   localparam int BPP_W     = 3;
   localparam int PIX_W     = 32;
   localparam int COORD_W   = 11;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_W     = 18;
   localparam int DEN_W     = 10;
   localparam int STEP_W    = 5;
   localparam int DIV_STEPS = 18;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BPP        = 2'd2;

   localparam logic [1:0] CHAN_FIRST = 2'd0;
   localparam logic [1:0] CHAN_LAST  = 2'd2;

   typedef struct packed {
      logic       accept;
      logic       sum;
      logic       div_step;
      logic       chan_store;
      logic       load_out;
      logic [1:0] chan;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic rgba;
   } status_type;

endpackage

// ===== sv/mbd_ctrl.sv =====
// Sequencing controller for the mip level box downsampler.
// Depends on mbd_pkg for the command and status structures.
module mbd_ctrl
   import mbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_DIV,
      S_STORE,
      S_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         chan_ff, chan_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.chan     = chan_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               chan_in    = CHAN_FIRST;
               if (status.emit) begin
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            cmd.sum = 1'b1;
            step_in = '0;
            if (status.rgba) begin
               state_in = S_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.chan_store = 1'b1;
            if (chan_ff == CHAN_LAST) begin
               state_in = S_OUT;
            end else begin
               chan_in  = chan_ff + 1'b1;
               state_in = S_SUM;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chan_ff      <= CHAN_FIRST;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("Result register loaded while a transaction was pending.");

   a_emit_starts: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.emit) |=> (state_ff == S_SUM))
      else $error("Emitting pixel did not start the filter sequence.");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (chan_ff <= CHAN_LAST))
      else $error("Channel index out of range during division.");

endmodule

// ===== sv/mbd_datapath.sv =====
// Datapath of the mip level box downsampler: raster counters, line store,
// quad registers, weighted sums, serial divider and result register. Uses mbd_pkg.
module mbd_datapath
   import mbd_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic [PIX_W-1:0]     req_src_pixel,
   input  cmd_type              cmd,
   output status_type           status,
   output logic [PIX_W-1:0]     rsp_dst_pixel,
   output logic [COORD_W-1:0]   rsp_dst_x,
   output logic [COORD_W-1:0]   rsp_dst_y,
   output logic                 rsp_last_of_level
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);

   logic [CFG_W-1:0]   width_ff, height_ff;
   logic [BPP_W-1:0]   bpp_ff;
   logic [XW-1:0]      x_ff;
   logic [YW-1:0]      y_ff;
   logic [PIX_W-1:0]   held_ff;
   logic [PIX_W-1:0]   line_mem [MAX_WIDTH];
   logic [PIX_W-1:0]   tl_mem_ff, tr_mem_ff, bl_ff, br_ff;
   logic               one_high_ff;
   logic [XW-1:0]      dx_ff;
   logic [YW-1:0]      dy_ff;
   logic               last_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [DEN_W-1:0]   den_ff, rem_ff;
   logic [PIX_W-1:0]   res_ff;
   logic [PIX_W-1:0]   out_pix_ff;
   logic [COORD_W-1:0] out_x_ff, out_y_ff;
   logic               out_last_ff;

   logic [31:0]        w32, h32;
   logic [XW:0]        sw;
   logic [YW:0]        sh;
   logic [XW-1:0]      dw, dx, xl;
   logic [YW-1:0]      dh, dy;
   logic [BPP_W-1:0]   bpp;
   logic               is_store, is_hold, wide, tall;
   logic [PIX_W-1:0]   q_tl, q_tr, q_bl, q_br;
   logic [DEN_W-1:0]   a_sum;
   logic [NUM_W-1:0]   s_chan;
   logic [PIX_W-1:0]   plain_res;
   logic [DEN_W:0]     trial;
   logic [DEN_W:0]     alpha_tmp;
   logic [9:0]         c_sum [4];

   always_comb begin
      w32 = 32'(width_ff);
      h32 = 32'(height_ff);
      if (w32 == 32'd0) begin
         sw = (XW+1)'(1);
      end else if (w32 > 32'(MAX_WIDTH)) begin
         sw = (XW+1)'(MAX_WIDTH);
      end else begin
         sw = (XW+1)'(w32);
      end
      if (h32 == 32'd0) begin
         sh = (YW+1)'(1);
      end else if (h32 > 32'(MAX_HEIGHT)) begin
         sh = (YW+1)'(MAX_HEIGHT);
      end else begin
         sh = (YW+1)'(h32);
      end
      if (bpp_ff == '0) begin
         bpp = BPP_W'(1);
      end else if (bpp_ff > BPP_W'(4)) begin
         bpp = BPP_W'(4);
      end else begin
         bpp = bpp_ff;
      end
   end

   assign wide     = (sw > (XW+1)'(1));
   assign tall     = (sh > (YW+1)'(1));
   assign dw       = wide ? XW'(sw >> 1) : XW'(1);
   assign dh       = tall ? YW'(sh >> 1) : YW'(1);
   assign dx       = wide ? (x_ff >> 1) : '0;
   assign dy       = tall ? (y_ff >> 1) : '0;
   assign xl       = wide ? (x_ff - 1'b1) : x_ff;
   assign is_store = tall && !y_ff[0];
   assign is_hold  = !is_store && wide && !x_ff[0];

   assign status.emit = !is_store && !is_hold && (dx < dw) && (dy < dh);
   assign status.rgba = (bpp == BPP_W'(4));

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(1);
         height_ff <= CFG_W'(1);
         bpp_ff    <= BPP_W'(4);
         x_ff      <= '0;
         y_ff      <= '0;
         held_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SRC_WIDTH: begin
               width_ff <= csr_wdata;
               x_ff     <= '0;
               y_ff     <= '0;
            end
            CSR_SRC_HEIGHT: begin
               height_ff <= csr_wdata;
               x_ff      <= '0;
               y_ff      <= '0;
            end
            CSR_BPP: begin
               bpp_ff <= csr_wdata[BPP_W-1:0];
               x_ff   <= '0;
               y_ff   <= '0;
            end
            default: begin
            end
         endcase
      end else if (cmd.accept) begin
         if (is_hold) begin
            held_ff <= req_src_pixel;
         end
         if ((XW+1)'(x_ff) + (XW+1)'(1) >= sw) begin
            x_ff <= '0;
            if ((YW+1)'(y_ff) + (YW+1)'(1) >= sh) begin
               y_ff <= '0;
            end else begin
               y_ff <= y_ff + 1'b1;
            end
         end else begin
            x_ff <= x_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && is_store) begin
         line_mem[x_ff] <= req_src_pixel;
      end
      if (cmd.accept) begin
         tl_mem_ff   <= line_mem[xl];
         tr_mem_ff   <= line_mem[x_ff];
         br_ff       <= req_src_pixel;
         bl_ff       <= wide ? held_ff : req_src_pixel;
         one_high_ff <= !tall;
         dx_ff       <= dx;
         dy_ff       <= dy;
         last_ff     <= (dx == dw - 1'b1) && (dy == dh - 1'b1);
      end
   end

   assign q_bl = bl_ff;
   assign q_br = br_ff;
   assign q_tl = one_high_ff ? bl_ff : tl_mem_ff;
   assign q_tr = one_high_ff ? br_ff : tr_mem_ff;

   always_comb begin
      a_sum = DEN_W'(q_tl[31:24]) + DEN_W'(q_tr[31:24])
            + DEN_W'(q_bl[31:24]) + DEN_W'(q_br[31:24]);
      s_chan = NUM_W'(q_tl[8*cmd.chan +: 8] * q_tl[31:24])
             + NUM_W'(q_tr[8*cmd.chan +: 8] * q_tr[31:24])
             + NUM_W'(q_bl[8*cmd.chan +: 8] * q_bl[31:24])
             + NUM_W'(q_br[8*cmd.chan +: 8] * q_br[31:24]);
      plain_res = '0;
      for (int c = 0; c < 4; c++) begin
         c_sum[c] = 10'(q_tl[8*c +: 8]) + 10'(q_tr[8*c +: 8])
                  + 10'(q_bl[8*c +: 8]) + 10'(q_br[8*c +: 8]) + 10'd2;
         if (BPP_W'(c) < bpp) begin
            plain_res[8*c +: 8] = c_sum[c][9:2];
         end
      end
      trial     = {rem_ff, num_ff[NUM_W-1]};
      alpha_tmp = (DEN_W+1)'(den_ff) + (DEN_W+1)'(2);
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         if (status.rgba) begin
            num_ff <= s_chan + NUM_W'(a_sum >> 1);
            den_ff <= a_sum;
            rem_ff <= '0;
         end else begin
            res_ff <= plain_res;
         end
      end else if (cmd.div_step) begin
         if (trial >= (DEN_W+1)'(den_ff)) begin
            rem_ff <= DEN_W'(trial - (DEN_W+1)'(den_ff));
            num_ff <= {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= DEN_W'(trial);
            num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         end
      end else if (cmd.chan_store) begin
         res_ff[8*cmd.chan +: 8] <= (den_ff == '0) ? 8'd0 : num_ff[7:0];
         if (cmd.chan == CHAN_LAST) begin
            res_ff[31:24] <= alpha_tmp[9:2];
         end
      end
      if (cmd.load_out) begin
         out_pix_ff  <= res_ff;
         out_x_ff    <= COORD_W'(dx_ff);
         out_y_ff    <= COORD_W'(dy_ff);
         out_last_ff <= last_ff;
      end
   end

   assign rsp_dst_pixel     = out_pix_ff;
   assign rsp_dst_x         = out_x_ff;
   assign rsp_dst_y         = out_y_ff;
   assign rsp_last_of_level = out_last_ff;

endmodule

// ===== sv/mipmap_box_downsampler_core.sv =====
// Top level of the 2x2 box-filter mip level downsampler.
// Instantiates mbd_ctrl and mbd_datapath; uses mbd_pkg.
// Source pixels are taken in raster order, and one destination pixel leaves for every
// 2x2 quad. Pixels that only fill the line store or the left-pixel holder stream at
// one per cycle between quads. A pixel that completes a quad is summed and then loaded
// into the output register in modes of one to three channels; in four-channel mode
// the three alpha-weighted colour channels first pass in turn through an 18-step
// bit-serial divider. A finished result waits in an output register while the next
// pixels are accepted. The line store needs no clearing pass after reset.
module mipmap_box_downsampler_core
   import mbd_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_src_pixel,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PIX_W-1:0]     rsp_dst_pixel,
   output logic [COORD_W-1:0]   rsp_dst_x,
   output logic [COORD_W-1:0]   rsp_dst_y,
   output logic                 rsp_last_of_level
);

   cmd_type    cmd;
   status_type status;

   mbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbd_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_src_pixel     (req_src_pixel),
      .cmd               (cmd),
      .status            (status),
      .rsp_dst_pixel     (rsp_dst_pixel),
      .rsp_dst_x         (rsp_dst_x),
      .rsp_dst_y         (rsp_dst_y),
      .rsp_last_of_level (rsp_last_of_level)
   );

endmodule

// ===== test/tb_mipmap_box_downsampler_core.sv =====
// Self-checking testbench for mipmap_box_downsampler_core, which it drives over its
// request, response and CSR ports with random idling; needs mbd_pkg and the core.
// Each response is matched to an in-bench 2x2 box-filter model or a table value.
`timescale 1ns / 100ps

module tb_mipmap_box_downsampler_core
   import mbd_pkg::*;
();

   localparam int MAXW       = DEF_MAX_WIDTH;
   localparam int MAXH       = DEF_MAX_HEIGHT;
   localparam int DRAIN_WAIT = 80;
   localparam int STALL_MAX  = 1000;

   typedef struct {
      logic [PIX_W-1:0]   pixel;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } dst_pix_type;

   typedef enum logic {ROW_CSR, ROW_PIX} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [CFG_W-1:0]     val;
      logic [PIX_W-1:0]     px;
      bit                   typed;
      logic [PIX_W-1:0]     exp_px;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_src_pixel = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   logic [PIX_W-1:0]     rsp_dst_pixel;
   logic [COORD_W-1:0]   rsp_dst_x;
   logic [COORD_W-1:0]   rsp_dst_y;
   logic                 rsp_last_of_level;

   dst_pix_type    expected_pixels[$];
   dir_row_type    dir_tab[$];
   int             errors = 0;
   int             sent = 0;
   int             idle_cycles = 0;
   int             rsp_hold = 0;
   bit             no_idle = 1'b0;

   logic [CFG_W-1:0] cfg_width = 13'd1;
   logic [CFG_W-1:0] cfg_height = 13'd1;
   logic [BPP_W-1:0] cfg_bpp = 3'd4;
   int unsigned      col_pos = 0;
   int unsigned      row_pos = 0;
   logic [PIX_W-1:0] held_left = '0;
   logic [PIX_W-1:0] even_line[MAXW];

   mipmap_box_downsampler_core u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   function automatic int unsigned eff_bpp();
      if (cfg_bpp == 0) return 1;
      if (cfg_bpp > 4) return 4;
      return cfg_bpp;
   endfunction

   function automatic int unsigned chan(input logic [PIX_W-1:0] p, input int c);
      return (p >> (8 * c)) & 32'hFF;
   endfunction

   function automatic logic [PIX_W-1:0] box_filter(input logic [PIX_W-1:0] p0,
         input logic [PIX_W-1:0] p1, input logic [PIX_W-1:0] p2, input logic [PIX_W-1:0] p3);
      int unsigned a, s, v, b;
      logic [PIX_W-1:0] res;
      res = '0;
      b = eff_bpp();
      if (b == 4) begin
         a = chan(p0, 3) + chan(p1, 3) + chan(p2, 3) + chan(p3, 3);
         for (int c = 0; c < 3; c++) begin
            v = 0;
            if (a != 0) begin
               s = chan(p0, c) * chan(p0, 3) + chan(p1, c) * chan(p1, 3)
                 + chan(p2, c) * chan(p2, 3) + chan(p3, c) * chan(p3, 3);
               v = (s + a / 2) / a;
            end
            res[8*c +: 8] = v[7:0];
         end
         v = (a + 2) / 4;
         res[31:24] = v[7:0];
      end else begin
         for (int c = 0; c < b; c++) begin
            s = chan(p0, c) + chan(p1, c) + chan(p2, c) + chan(p3, c);
            v = (s + 2) / 4;
            res[8*c +: 8] = v[7:0];
         end
      end
      return res;
   endfunction

   // Advances the model by one accepted source pixel and queues any finished quad.
   task automatic model_pixel(input logic [PIX_W-1:0] px, input bit typed,
         input logic [PIX_W-1:0] typed_px);
      int unsigned w, h, dw, dh, x, y, xl, dx, dy;
      logic [PIX_W-1:0] tl, tr, bl, br;
      dst_pix_type e;
      w = eff_size(cfg_width, MAXW);
      h = eff_size(cfg_height, MAXH);
      dw = (w >> 1) ? (w >> 1) : 1;
      dh = (h >> 1) ? (h >> 1) : 1;
      x = (col_pos >= w) ? 0 : col_pos;
      y = (row_pos >= h) ? 0 : row_pos;
      if (h > 1 && y % 2 == 0) begin
         even_line[x] = px;
      end else if (w > 1 && x % 2 == 0) begin
         held_left = px;
      end else begin
         xl = (w > 1) ? x - 1 : x;
         bl = (w > 1) ? held_left : px;
         br = px;
         if (h > 1) begin
            tl = even_line[xl];
            tr = even_line[x];
         end else begin
            tl = bl;
            tr = br;
         end
         dx = (w > 1) ? (x >> 1) : 0;
         dy = (h > 1) ? (y >> 1) : 0;
         if (dx < dw && dy < dh) begin
            e.pixel = typed ? typed_px : box_filter(tl, tr, bl, br);
            e.x = dx[COORD_W-1:0];
            e.y = dy[COORD_W-1:0];
            e.last = (dx == dw - 1 && dy == dh - 1);
            expected_pixels = {expected_pixels, e};
         end
      end
      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) y = 0;
      end
      col_pos = x;
      row_pos = y;
   endtask

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   task automatic add_row(input row_kind_type kind, input logic [CSR_IDX_W-1:0] idx,
         input logic [CFG_W-1:0] val, input logic [PIX_W-1:0] px, input bit typed,
         input logic [PIX_W-1:0] exp_px);
      dir_row_type r;
      r = '{kind, idx, val, px, typed, exp_px};
      dir_tab = {dir_tab, r};
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed = 1'b0,
         input logic [PIX_W-1:0] typed_px = '0);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_src_pixel <= px;
      do @(posedge clock); while (!req_ready);
      model_pixel(px, typed, typed_px);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_SRC_WIDTH:  cfg_width = val;
         CSR_SRC_HEIGHT: cfg_height = val;
         CSR_BPP:        cfg_bpp = val[BPP_W-1:0];
         default: ;
      endcase
      col_pos = 0;
      row_pos = 0;
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel();
      logic [PIX_W-1:0] v;
      v = $urandom;
      if ($urandom_range(0, 7) == 0) v[31:24] = 8'h00;
      return v;
   endfunction

   task automatic run_level(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
         input logic [CFG_W-1:0] b, input int count);
      csr_write(CSR_SRC_WIDTH, w);
      csr_write(CSR_SRC_HEIGHT, h);
      csr_write(CSR_BPP, b);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < count; i++) send_pixel(rand_pixel());
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report("response with nothing expected");
            end else begin
               dst_pix_type e;
               e = expected_pixels.pop_front();
               if (rsp_dst_pixel !== e.pixel)
                  report($sformatf("pixel %h, expected %h", rsp_dst_pixel, e.pixel));
               if (rsp_dst_x !== e.x)
                  report($sformatf("dst_x %0d, expected %0d", rsp_dst_x, e.x));
               if (rsp_dst_y !== e.y)
                  report($sformatf("dst_y %0d, expected %0d", rsp_dst_y, e.y));
               if (rsp_last_of_level !== e.last)
                  report($sformatf("last %b, expected %b", rsp_last_of_level, e.last));
            end
            rsp_hold = no_idle ? 0 : $urandom_range(0, 5);
            rsp_ready <= (rsp_hold == 0);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= (rsp_hold == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_MAX) begin
            $display("mipmap_box_downsampler_core test failed");
            $finish;
         end
      end
   end

   initial begin
      int n, w, h;
      add_row(ROW_PIX, '0, '0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF);
      add_row(ROW_PIX, '0, '0, 32'h00FFFFFF, 1'b1, 32'h00000000);
      add_row(ROW_PIX, '0, '0, 32'h80102030, 1'b1, 32'h80102030);
      add_row(ROW_CSR, CSR_BPP, 13'd0, '0, 1'b0, '0);
      add_row(ROW_PIX, '0, '0, 32'h12345678, 1'b1, 32'h00000078);
      add_row(ROW_CSR, CSR_BPP, 13'd7, '0, 1'b0, '0);
      add_row(ROW_CSR, CSR_SRC_WIDTH, 13'd3, '0, 1'b0, '0);
      add_row(ROW_CSR, CSR_SRC_HEIGHT, 13'd3, '0, 1'b0, '0);
      for (int i = 0; i < 9; i++)
         add_row(ROW_PIX, '0, '0, (i % 2) ? 32'hFF00FF00 : 32'h00FF00FF + i, 1'b0, '0);
      add_row(ROW_CSR, CSR_SRC_WIDTH, 13'd0, '0, 1'b0, '0);
      add_row(ROW_CSR, CSR_SRC_HEIGHT, 13'd2, '0, 1'b0, '0);
      add_row(ROW_CSR, CSR_BPP, 13'd2, '0, 1'b0, '0);
      add_row(ROW_PIX, '0, '0, 32'hA5A5A5A5, 1'b0, '0);
      add_row(ROW_PIX, '0, '0, 32'h5A5A5A5A, 1'b0, '0);
      add_row(ROW_CSR, CSR_SRC_WIDTH, 13'd4, '0, 1'b0, '0);
      for (int i = 0; i < 3; i++)
         add_row(ROW_PIX, '0, '0, 32'h01020304 * (i + 1), 1'b0, '0);
      add_row(ROW_CSR, CSR_SRC_WIDTH, 13'd2, '0, 1'b0, '0);
      for (int i = 0; i < 4; i++)
         add_row(ROW_PIX, '0, '0, 32'hFFFFFFFF - i, 1'b0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) csr_write(dir_tab[i].idx, dir_tab[i].val);
         else send_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].exp_px);
      end

      while (sent < 330) begin
         n = $urandom_range(0, 19);
         w = (n == 0) ? 0 : (n == 1) ? 1 : $urandom_range(2, 12);
         n = $urandom_range(0, 19);
         h = (n == 0) ? 0 : (n == 1) ? 1 : $urandom_range(2, 7);
         n = eff_size(CFG_W'(w), MAXW) * eff_size(CFG_W'(h), MAXH) * $urandom_range(1, 2);
         if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
         run_level(CFG_W'(w), CFG_W'(h), CFG_W'($urandom_range(0, 7)), n);
      end

      run_level(13'd8191, 13'd1, 13'd1, 64);
      run_level(13'd1, 13'd8191, 13'd3, 64);
      run_level(13'd4096, 13'd2, 13'd4, 64);

      drain();
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("mipmap_box_downsampler_core test passed");
      end else begin
         $display("mipmap_box_downsampler_core test failed");
      end
      $finish;
   end

endmodule
